@@ src/ipi_coalescer_with_latency_stats_assert.svh @@
// Assertion macros for the checker.
`ifndef IPI_COALESCER_WITH_LATENCY_STATS_ASSERT_SVH
`define IPI_COALESCER_WITH_LATENCY_STATS_ASSERT_SVH

// expr must hold on every clock edge outside reset
`define IPC_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("ipc assertion failed");

// cons must hold in the cycle after ante
`define IPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipc assertion failed");

`endif

@@ src/ipc_pkg.sv @@
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared types, codes and constants of the IPI coalescer.
// ----------------------------------------------------------------------------
`default_nettype none
package ipc_pkg;

    localparam int NUM_CPUS_DEF  = 8;
    localparam int NUM_TYPES_DEF = 8;

    localparam logic [63:0] NS_PER_SEC = 64'd1_000_000_000;

    // configuration register indexes
    localparam logic CFG_FREQ   = 1'b0;
    localparam logic CFG_ONLINE = 1'b1;

    // request codes
    localparam logic [1:0] REQ_SEND  = 2'd0;
    localparam logic [1:0] REQ_BCAST = 2'd1;
    localparam logic [1:0] REQ_DRAIN = 2'd2;
    localparam logic [1:0] REQ_QUERY = 2'd3;

    // shared arithmetic unit operations
    localparam logic MD_MUL = 1'b0;
    localparam logic MD_DIV = 1'b1;

    // operand selections for the arithmetic unit
    localparam logic [1:0] SEL_MUL_TICKS = 2'd0;
    localparam logic [1:0] SEL_DIV_FREQ  = 2'd1;
    localparam logic [1:0] SEL_MUL_AVG   = 2'd2;
    localparam logic [1:0] SEL_DIV_AVG   = 2'd3;

    // result kinds
    localparam logic [2:0] K_BAD   = 3'd0;
    localparam logic [2:0] K_SEND  = 3'd1;
    localparam logic [2:0] K_MASK  = 3'd2;
    localparam logic [2:0] K_TYPE  = 3'd3;
    localparam logic [2:0] K_EMPTY = 3'd4;
    localparam logic [2:0] K_QUERY = 3'd5;

    typedef struct packed {
        logic       in_ready;
        logic       send_do;
        logic       bc_init;
        logic       bc_step;
        logic       drain_init;
        logic       scan_next;
        logic       stamp_rd;
        logic       md_start;
        logic [1:0] md_sel;
        logic       ns_load;
        logic       rec_minmax;
        logic       avg_wr;
        logic       cnt_wr;
        logic       emit;
        logic [2:0] kind;
    } t_cmd;

    typedef struct packed {
        logic       req_valid;
        logic [1:0] req_type;
        logic       cpu_ok;
        logic       typ_ok;
        logic       target_on;
        logic       c_last;
        logic       pend_zero;
        logic       pend_bit;
        logic       pend_last;
        logic       stamp_use;
        logic       ns_zero;
        logic       next_zero;
        logic       md_done;
        logic       out_free;
    } t_sts;

endpackage
`default_nettype wire

@@ src/ipc_ifs.sv @@
// ----------------------------------------------------------------------------
// ipc channel interfaces
// Request, result and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface ipc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [3:0]  cpu;
    logic [4:0]  irq_type;
    logic        skip_requester;
    logic [63:0] now_ticks;
    modport source (output valid, req_type, cpu, irq_type, skip_requester, now_ticks,
                    input ready);
    modport sink   (input valid, req_type, cpu, irq_type, skip_requester, now_ticks,
                    output ready);
endinterface

interface ipc_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [7:0]  doorbell_mask;
    logic        has_type;
    logic [4:0]  drained_type;
    logic        last;
    logic [63:0] min_ns;
    logic [63:0] max_ns;
    logic [63:0] avg_ns;
    logic [63:0] sample_count;
    modport source (output valid, status, doorbell_mask, has_type, drained_type, last,
                    min_ns, max_ns, avg_ns, sample_count, input ready);
    modport sink   (input valid, status, doorbell_mask, has_type, drained_type, last,
                    min_ns, max_ns, avg_ns, sample_count, output ready);
endinterface

interface ipc_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ src/ipc_ram.sv @@
// ----------------------------------------------------------------------------
// ipc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module ipc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

@@ src/ipc_muldiv.sv @@
// ----------------------------------------------------------------------------
// ipc_muldiv
// Iterative 64-bit unit: shift-add multiply (low 64 bits) or restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none
module ipc_muldiv (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic        i_op,
    input  wire logic [63:0] i_a,
    input  wire logic [63:0] i_b,
    output logic             o_done,
    output logic      [63:0] o_res
);
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic        r_op;
    logic [5:0]  r_cnt;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_acc;
    logic [63:0] r_rem;
    logic [64:0] w_sh;
    logic        w_ge;

    assign w_sh = {r_rem, r_acc[63]};
    assign w_ge = w_sh >= {1'b0, r_b};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_busy = 1'b1;
        end else if (r_busy) begin
            if ((r_op == ipc_pkg::MD_MUL && r_b[63:1] == 63'd0) ||
                (r_op == ipc_pkg::MD_DIV && r_cnt == 6'd63)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op  <= i_op;
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= (i_op == ipc_pkg::MD_MUL) ? 64'd0 : i_a;
            r_rem <= 64'd0;
            r_cnt <= 6'd0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (r_op == ipc_pkg::MD_MUL) begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a <= {r_a[62:0], 1'b0};
                r_b <= {1'b0, r_b[63:1]};
            end else begin
                // remainder stays below the divisor, so 64 bits hold it
                r_rem <= 64'(w_ge ? (w_sh - {1'b0, r_b}) : w_sh);
                r_acc <= {r_acc[62:0], w_ge};
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc;
endmodule
`default_nettype wire

@@ src/ipc_ctrl.sv @@
// ----------------------------------------------------------------------------
// ipc_ctrl
// Sequencer: decodes a request and steps the datapath through it.
// ----------------------------------------------------------------------------
`default_nettype none
module ipc_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire ipc_pkg::t_sts i_sts,
    output ipc_pkg::t_cmd      o_cmd
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_BCAST  = 4'd2;
    localparam logic [3:0] S_DSTART = 4'd3;
    localparam logic [3:0] S_DSCAN  = 4'd4;
    localparam logic [3:0] S_DCHK   = 4'd5;
    localparam logic [3:0] S_DMUL1  = 4'd6;
    localparam logic [3:0] S_DDIV1  = 4'd7;
    localparam logic [3:0] S_DREC   = 4'd8;
    localparam logic [3:0] S_DREC2  = 4'd9;
    localparam logic [3:0] S_DMUL2  = 4'd10;
    localparam logic [3:0] S_DDIV2  = 4'd11;
    localparam logic [3:0] S_EMIT   = 4'd12;

    logic [3:0] r_state, n_state;
    logic [2:0] r_kind, n_kind;

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '0;
        o_cmd.kind = r_kind;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.req_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_EMIT;
                n_kind  = ipc_pkg::K_BAD;
                unique case (i_sts.req_type)
                    ipc_pkg::REQ_SEND: begin
                        if (i_sts.cpu_ok && i_sts.typ_ok && i_sts.target_on) begin
                            o_cmd.send_do = 1'b1;
                            n_kind = ipc_pkg::K_SEND;
                        end
                    end
                    ipc_pkg::REQ_BCAST: begin
                        if (i_sts.typ_ok) begin
                            o_cmd.bc_init = 1'b1;
                            n_state = S_BCAST;
                        end
                    end
                    ipc_pkg::REQ_DRAIN: begin
                        if (i_sts.cpu_ok) begin
                            o_cmd.drain_init = 1'b1;
                            n_state = S_DSTART;
                        end
                    end
                    ipc_pkg::REQ_QUERY: begin
                        if (i_sts.cpu_ok) begin
                            n_kind = ipc_pkg::K_QUERY;
                        end
                    end
                    default: ;
                endcase
            end
            S_BCAST: begin
                o_cmd.bc_step = 1'b1;
                if (i_sts.c_last) begin
                    n_kind  = ipc_pkg::K_MASK;
                    n_state = S_EMIT;
                end
            end
            S_DSTART: begin
                if (i_sts.pend_zero) begin
                    n_kind  = ipc_pkg::K_EMPTY;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_DSCAN;
                end
            end
            S_DSCAN: begin
                if (i_sts.pend_bit) begin
                    o_cmd.stamp_rd = 1'b1;
                    n_state = S_DCHK;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            S_DCHK: begin
                n_kind = ipc_pkg::K_TYPE;
                if (i_sts.stamp_use) begin
                    o_cmd.md_start = 1'b1;
                    o_cmd.md_sel   = ipc_pkg::SEL_MUL_TICKS;
                    n_state = S_DMUL1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_DMUL1: begin
                if (i_sts.md_done) begin
                    o_cmd.md_start = 1'b1;
                    o_cmd.md_sel   = ipc_pkg::SEL_DIV_FREQ;
                    n_state = S_DDIV1;
                end
            end
            S_DDIV1: begin
                if (i_sts.md_done) begin
                    o_cmd.ns_load = 1'b1;
                    n_state = S_DREC;
                end
            end
            S_DREC: begin
                if (i_sts.ns_zero) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.rec_minmax = 1'b1;
                    n_state = S_DREC2;
                end
            end
            S_DREC2: begin
                if (i_sts.next_zero) begin
                    // count wraps: average stays as it is
                    o_cmd.cnt_wr = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.md_start = 1'b1;
                    o_cmd.md_sel   = ipc_pkg::SEL_MUL_AVG;
                    n_state = S_DMUL2;
                end
            end
            S_DMUL2: begin
                if (i_sts.md_done) begin
                    o_cmd.md_start = 1'b1;
                    o_cmd.md_sel   = ipc_pkg::SEL_DIV_AVG;
                    n_state = S_DDIV2;
                end
            end
            S_DDIV2: begin
                if (i_sts.md_done) begin
                    o_cmd.avg_wr = 1'b1;
                    o_cmd.cnt_wr = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_kind == ipc_pkg::K_TYPE && !i_sts.pend_last) begin
                        n_state = S_DSCAN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= ipc_pkg::K_BAD;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end
endmodule
`default_nettype wire

@@ src/ipc_dp.sv @@
// ----------------------------------------------------------------------------
// ipc_dp
// Datapath: config, pending words, stamp RAM, statistics, result register.
// ----------------------------------------------------------------------------
`default_nettype none
module ipc_dp #(
    parameter int NUM_CPUS  = ipc_pkg::NUM_CPUS_DEF,
    parameter int NUM_TYPES = ipc_pkg::NUM_TYPES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    ipc_req_if.sink            i_req,
    ipc_rsp_if.source          o_rsp,
    ipc_cfg_if.sink            i_cfg,
    input  wire ipc_pkg::t_cmd i_cmd,
    output ipc_pkg::t_sts      o_sts
);
    localparam int CW    = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int TW    = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int AW    = CW + TW;
    localparam int DEPTH = 2 ** AW;
    localparam logic [CW-1:0]        LAST_CPU = CW'(NUM_CPUS - 1);
    localparam logic [NUM_TYPES-1:0] ONE_T    = NUM_TYPES'(1);

    // configuration
    logic [31:0] r_freq;
    logic [7:0]  r_online;

    // latched request
    logic [1:0]  r_req_type;
    logic [3:0]  r_cpu;
    logic [4:0]  r_typ;
    logic        r_excl;
    logic [63:0] r_now;

    // working registers
    logic [NUM_TYPES-1:0] r_pending [NUM_CPUS];
    logic [NUM_TYPES-1:0] r_pend;
    logic [TW-1:0]        r_t;
    logic [CW-1:0]        r_c;
    logic [7:0]           r_mask;
    logic [63:0]          r_ns;
    logic [63:0]          r_next;
    logic [DEPTH-1:0]     r_svld;
    logic                 r_rvld;

    // statistics
    logic [63:0] r_min [NUM_CPUS];
    logic [63:0] r_max [NUM_CPUS];
    logic [63:0] r_avg [NUM_CPUS];
    logic [63:0] r_cnt [NUM_CPUS];

    // result register
    logic        r_out_vld;
    logic        r_o_status;
    logic [7:0]  r_o_mask;
    logic        r_o_has;
    logic [4:0]  r_o_type;
    logic        r_o_last;
    logic [63:0] r_o_min, r_o_max, r_o_avg, r_o_cnt;

    logic [CW-1:0] w_cidx;
    logic [TW-1:0] w_tidx;
    logic          w_accept;
    logic          w_bc_sel;
    logic          w_pend_last;
    logic [63:0]   w_rdata;
    logic [63:0]   w_stamp;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [63:0]   w_md_a, w_md_b, w_md_res;
    logic          w_md_op, w_md_done;

    assign w_cidx   = r_cpu[CW-1:0];
    assign w_tidx   = r_typ[TW-1:0];
    assign w_accept = i_req.valid && i_cmd.in_ready;
    assign w_bc_sel = r_online[3'(r_c)] && !(r_excl && (r_cpu == 4'(r_c)));
    assign w_pend_last = (r_pend & ~(ONE_T << r_t)) == '0;
    assign w_stamp  = r_rvld ? w_rdata : 64'd0;

    assign i_req.ready = i_cmd.in_ready;
    assign i_cfg.ready = 1'b1;

    // stamp store writes: one send, or one cpu per broadcast step
    assign w_we    = i_cmd.send_do || (i_cmd.bc_step && w_bc_sel);
    assign w_waddr = i_cmd.send_do ? {w_cidx, w_tidx} : {r_c, w_tidx};

    ipc_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_stamp (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_now),
        .i_re    (i_cmd.stamp_rd),
        .i_raddr ({w_cidx, r_t}),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_md_op = ipc_pkg::MD_MUL;
        w_md_a  = r_now - w_stamp;
        w_md_b  = ipc_pkg::NS_PER_SEC;
        case (i_cmd.md_sel)
            ipc_pkg::SEL_DIV_FREQ: begin
                w_md_op = ipc_pkg::MD_DIV;
                w_md_a  = w_md_res;
                w_md_b  = {32'd0, r_freq};
            end
            ipc_pkg::SEL_MUL_AVG: begin
                w_md_a  = r_avg[w_cidx];
                w_md_b  = r_cnt[w_cidx];
            end
            ipc_pkg::SEL_DIV_AVG: begin
                w_md_op = ipc_pkg::MD_DIV;
                w_md_a  = w_md_res + r_ns;
                w_md_b  = r_next;
            end
            default: ;
        endcase
    end

    ipc_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.md_start),
        .i_op    (w_md_op),
        .i_a     (w_md_a),
        .i_b     (w_md_b),
        .o_done  (w_md_done),
        .o_res   (w_md_res)
    );

    always_comb begin
        o_sts.req_valid = i_req.valid;
        o_sts.req_type  = r_req_type;
        o_sts.cpu_ok    = r_cpu < 4'(NUM_CPUS);
        o_sts.typ_ok    = {1'b0, r_typ} < 6'(NUM_TYPES);
        o_sts.target_on = r_online[r_cpu[2:0]];
        o_sts.c_last    = r_c == LAST_CPU;
        o_sts.pend_zero = r_pend == '0;
        o_sts.pend_bit  = r_pend[r_t];
        o_sts.pend_last = w_pend_last;
        o_sts.stamp_use = (w_stamp != 64'd0) && (r_now > w_stamp) && (r_freq != 32'd0);
        o_sts.ns_zero   = r_ns == 64'd0;
        o_sts.next_zero = r_next == 64'd0;
        o_sts.md_done   = w_md_done;
        o_sts.out_free  = !r_out_vld || o_rsp.ready;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_type <= i_req.req_type;
            r_cpu      <= i_req.cpu;
            r_typ      <= i_req.irq_type;
            r_excl     <= i_req.skip_requester;
            r_now      <= i_req.now_ticks;
        end
        if (i_cmd.stamp_rd) begin
            r_rvld <= r_svld[{w_cidx, r_t}];
        end
        if (i_cmd.ns_load) begin
            r_ns <= w_md_res;
        end
        if (i_cmd.rec_minmax) begin
            r_next <= r_cnt[w_cidx] + 64'd1;
        end
        if (i_cmd.bc_init) begin
            r_c    <= '0;
            r_mask <= 8'd0;
        end else if (i_cmd.bc_step) begin
            if (w_bc_sel) begin
                r_mask[3'(r_c)] <= 1'b1;
            end
            r_c <= r_c + CW'(1);
        end
        if (i_cmd.drain_init) begin
            r_pend <= r_pending[w_cidx];
            r_t    <= '0;
        end else if (i_cmd.scan_next) begin
            r_t <= r_t + TW'(1);
        end else if (i_cmd.emit && i_cmd.kind == ipc_pkg::K_TYPE) begin
            r_pend <= r_pend & ~(ONE_T << r_t);
        end
        if (i_cmd.emit) begin
            r_o_status <= 1'b0;
            r_o_mask   <= 8'd0;
            r_o_has    <= 1'b0;
            r_o_type   <= 5'd0;
            r_o_last   <= 1'b1;
            r_o_min    <= 64'd0;
            r_o_max    <= 64'd0;
            r_o_avg    <= 64'd0;
            r_o_cnt    <= 64'd0;
            case (i_cmd.kind)
                ipc_pkg::K_BAD:  r_o_status <= 1'b1;
                ipc_pkg::K_SEND: r_o_mask   <= 8'd1 << r_cpu[2:0];
                ipc_pkg::K_MASK: r_o_mask   <= r_mask;
                ipc_pkg::K_TYPE: begin
                    r_o_has  <= 1'b1;
                    r_o_type <= 5'(r_t);
                    r_o_last <= w_pend_last;
                end
                ipc_pkg::K_QUERY: begin
                    r_o_min <= r_min[w_cidx];
                    r_o_max <= r_max[w_cidx];
                    r_o_avg <= r_avg[w_cidx];
                    r_o_cnt <= r_cnt[w_cidx];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq    <= 32'd0;
            r_online  <= 8'd1;
            r_out_vld <= 1'b0;
            r_svld    <= '0;
            for (int i = 0; i < NUM_CPUS; i++) begin
                r_pending[i] <= '0;
                r_min[i]     <= 64'd0;
                r_max[i]     <= 64'd0;
                r_avg[i]     <= 64'd0;
                r_cnt[i]     <= 64'd0;
            end
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.index == ipc_pkg::CFG_FREQ) begin
                    r_freq <= i_cfg.data;
                end else begin
                    r_online <= i_cfg.data[7:0];
                end
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
            if (w_we) begin
                r_svld[w_waddr] <= 1'b1;
            end
            if (i_cmd.send_do) begin
                r_pending[w_cidx][w_tidx] <= 1'b1;
            end
            if (i_cmd.bc_step && w_bc_sel) begin
                r_pending[r_c][w_tidx] <= 1'b1;
            end
            if (i_cmd.drain_init) begin
                r_pending[w_cidx] <= '0;
            end
            if (i_cmd.rec_minmax) begin
                if (r_cnt[w_cidx] == 64'd0 || r_ns < r_min[w_cidx]) begin
                    r_min[w_cidx] <= r_ns;
                end
                if (r_ns > r_max[w_cidx]) begin
                    r_max[w_cidx] <= r_ns;
                end
            end
            if (i_cmd.avg_wr) begin
                r_avg[w_cidx] <= w_md_res;
            end
            if (i_cmd.cnt_wr) begin
                r_cnt[w_cidx] <= r_next;
            end
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.status        = r_o_status;
    assign o_rsp.doorbell_mask = r_o_mask;
    assign o_rsp.has_type      = r_o_has;
    assign o_rsp.drained_type  = r_o_type;
    assign o_rsp.last          = r_o_last;
    assign o_rsp.min_ns        = r_o_min;
    assign o_rsp.max_ns        = r_o_max;
    assign o_rsp.avg_ns        = r_o_avg;
    assign o_rsp.sample_count  = r_o_cnt;
endmodule
`default_nettype wire

@@ src/ipi_coalescer_with_latency_stats.sv @@
// Send, query and rejected requests pass IDLE, DECODE and EMIT before their item is
// registered; a broadcast steps through each CPU in BCAST first. A drain scans one type
// per cycle until it finds a pending one and, per usable stamp, runs the shared
// iterative mul/div unit up to four times (multiply, divide, multiply, divide).
// One request is worked at a time; the next is taken while the last item waits.
// Reset is synchronous: pending words, stamp valid bits and statistics clear at once, no sweep.
// ----------------------------------------------------------------------------
// ipi_coalescer_with_latency_stats
// IPI coalescer with per-CPU delivery latency statistics.
// ----------------------------------------------------------------------------
`default_nettype none
module ipi_coalescer_with_latency_stats #(
    parameter int NUM_CPUS  = ipc_pkg::NUM_CPUS_DEF,
    parameter int NUM_TYPES = ipc_pkg::NUM_TYPES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ipc_req_if.sink   i_req,
    ipc_rsp_if.source o_rsp,
    ipc_cfg_if.sink   i_cfg
);
    ipc_pkg::t_cmd w_cmd;
    ipc_pkg::t_sts w_sts;

    ipc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ipc_dp #(.NUM_CPUS(NUM_CPUS), .NUM_TYPES(NUM_TYPES)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cfg   (i_cfg),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );
endmodule
`default_nettype wire

@@ src/ipc_checker.sv @@
// ----------------------------------------------------------------------------
// ipc_checker
// Port-level checks of the coalescer result channel.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ipi_coalescer_with_latency_stats_assert.svh"
module ipc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        i_ready,
    input wire logic        i_status,
    input wire logic [7:0]  i_mask,
    input wire logic        i_has,
    input wire logic [4:0]  i_type,
    input wire logic        i_last
);
    // a stalled item holds
    `IPC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_valid && !i_ready,
        i_valid && $stable(i_mask) && $stable(i_type) && $stable(i_last))
    // an error item is alone and carries nothing else
    `IPC_ASSERT_ALWAYS(a_err, i_clk, i_rst_n,
        !(i_valid && i_status) || (i_mask == 8'd0 && !i_has && i_last))
    // only a drained type may be followed by more items
    `IPC_ASSERT_ALWAYS(a_last, i_clk, i_rst_n, !i_valid || i_has || i_last)
    // doorbells and drained types never mix
    `IPC_ASSERT_ALWAYS(a_mix, i_clk, i_rst_n, !(i_valid && i_has) || i_mask == 8'd0)
endmodule

bind ipi_coalescer_with_latency_stats ipc_checker u_ipc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_rsp.valid),
    .i_ready  (o_rsp.ready),
    .i_status (o_rsp.status),
    .i_mask   (o_rsp.doorbell_mask),
    .i_has    (o_rsp.has_type),
    .i_type   (o_rsp.drained_type),
    .i_last   (o_rsp.last)
);
`default_nettype wire
